// ===== hdl/cbac_pkg.sv =====
// Shared types, constants and helpers for the cluster band access controller.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package cbac_pkg;

	localparam int NUM_HEADS   = 5;
	localparam int NUM_BANDS   = 19;
	localparam int SHARED_BAND = NUM_BANDS;
	localparam int HEAD_W      = 3;
	localparam int BAND_W      = 5;
	localparam int BO_W        = 10;
	localparam int INIT_W      = 3;
	localparam int JIT_W       = 5;
	localparam logic [BO_W-1:0] BO_LIMIT_RST = BO_W'(512);

	typedef enum logic [1:0] {
		MODE_SEARCHING = 2'd0,
		MODE_NORMAL    = 2'd1,
		MODE_DISPLACED = 2'd2,
		MODE_UNDERLAY  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_SCAN,
		ST_FINISH
	} ctrl_state_t;

	typedef logic [HEAD_W-1:0] head_t;
	typedef logic [BAND_W-1:0] band_t;
	typedef logic [BO_W-1:0] bo_t;
	typedef logic [NUM_BANDS-1:0] pu_t;
	typedef mode_t [NUM_HEADS-1:0] mode_arr_t;
	typedef band_t [NUM_HEADS-1:0] band_arr_t;

	typedef struct packed {
		logic  done;
		logic  found;
		band_t band;
	} scan_res_t;

	// bands outside the regular range never carry a primary user
	function automatic logic band_busy(pu_t pu, band_t b);
		logic busy;
		busy = 1'b0;
		if (b < BAND_W'(NUM_BANDS)) begin
			busy = pu[b];
		end
		return busy;
	endfunction

endpackage

// ===== hdl/cbac_band_scan.sv =====
// Free-band search unit: one regular band per cycle, compared against primary users and every other normal-mode head.
// Depends on cbac_pkg.
`timescale 1ns / 1ps

module cbac_band_scan (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  cbac_pkg::head_t     self,
	input  cbac_pkg::pu_t       pu_active,
	input  cbac_pkg::mode_arr_t head_mode,
	input  cbac_pkg::band_arr_t head_band,
	output cbac_pkg::scan_res_t result
);
	import cbac_pkg::*;

	band_t m_q;
	logic  busy_q;
	logic  taken;
	logic  last;

	always_comb begin
		taken = band_busy(pu_active, m_q);
		for (int k = 0; k < NUM_HEADS; k++) begin
			if (HEAD_W'(k) != self && head_mode[k] == MODE_NORMAL && head_band[k] == m_q) begin
				taken = 1'b1;
			end
		end
	end

	assign last         = (m_q == BAND_W'(NUM_BANDS - 1));
	assign result.done  = busy_q && (!taken || last);
	assign result.found = busy_q && !taken;
	assign result.band  = m_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			m_q    <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			m_q    <= '0;
		end else if (busy_q) begin
			if (!taken || last) begin
				busy_q <= 1'b0;
			end else begin
				m_q <= m_q + BAND_W'(1);
			end
		end
	end

endmodule

// ===== hdl/cluster_band_access_controller_unit.sv =====
// Cluster band access controller: per-head mode, band and backoff with a sequencer.
// Depends on cbac_pkg and cbac_band_scan.
// Sequence: accept in idle, evaluate, scan the regular bands (one band per cycle) for a
// searching/underlay head, then finish; displaced/normal heads and an invalid head skip the scan.
// A new item is taken only after the current one has finished; a stalled result holds finish.
// Reset: all heads searching, band 0, backoff 0, backoff limit 512; clears at once.
`timescale 1ns / 1ps

module cluster_band_access_controller_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [cbac_pkg::HEAD_W-1:0]          head,
	input  logic [cbac_pkg::NUM_BANDS-1:0]       pu_active,
	input  logic [cbac_pkg::INIT_W-1:0]          initial_backoff,
	input  logic                                 collision,
	input  logic                                 backoff_fail,
	input  logic [cbac_pkg::JIT_W-1:0]           jitter,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [cbac_pkg::HEAD_W-1:0]          head_out,
	output logic [1:0]                           mode,
	output logic [cbac_pkg::BAND_W-1:0]          band,
	output logic [cbac_pkg::BO_W-1:0]            backoff,
	output logic                                 delivered,
	output logic                                 outage_begin,
	output logic                                 underlay_attempt,
	output logic                                 underlay_success,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [cbac_pkg::BO_W-1:0]            backoff_limit
);
	import cbac_pkg::*;

	ctrl_state_t state_q, state_nx;

	mode_arr_t mode_q;
	band_arr_t band_q;
	bo_t       bo_q [NUM_HEADS];
	bo_t       max_bo_q;

	// latched item
	head_t                head_q;
	pu_t                  pu_q;
	logic [INIT_W-1:0]    init_q;
	logic                 col_q;
	logic                 fail_q;
	logic [JIT_W-1:0]     jit_q;

	// step result under construction
	logic  head_ok_q;
	logic  was_normal_q;
	mode_t nmode_q;
	band_t nband_q;
	bo_t   nbo_q;
	logic  attempt_q;
	logic  success_q;

	// output register
	logic  out_valid_q;
	head_t out_head_q;
	mode_t out_mode_q;
	band_t out_band_q;
	bo_t   out_bo_q;
	logic  out_deliv_q;
	logic  out_outage_q;
	logic  out_att_q;
	logic  out_succ_q;

	// evaluation of the displaced path
	logic                head_ok;
	mode_t               cur_mode;
	band_t               cur_band;
	bo_t                 cur_bo;
	mode_t               e_mode;
	band_t               e_band;
	bo_t                 e_bo;
	logic                e_att;
	logic                e_succ;
	logic [BO_W+1:0]     v;
	logic                need_scan;

	logic      accept;
	logic      scan_start;
	logic      fin_go;
	scan_res_t scan_res;

	assign accept    = in_valid && !in_stall;
	assign head_ok   = (head_q < HEAD_W'(NUM_HEADS));
	assign cur_mode  = mode_q[head_q];
	assign cur_band  = band_q[head_q];
	assign cur_bo    = bo_q[head_q];
	assign cfg_ready = 1'b1;

	always_comb begin
		e_mode = cur_mode;
		e_band = cur_band;
		e_bo   = cur_bo;
		e_att  = 1'b0;
		e_succ = 1'b0;
		v      = '0;
		if (cur_mode == MODE_NORMAL && band_busy(pu_q, cur_band)) begin
			e_mode = MODE_DISPLACED;
			e_bo   = BO_W'(init_q);
		end
		if (e_mode == MODE_DISPLACED) begin
			if (e_bo != '0) begin
				e_bo = e_bo - BO_W'(1);
			end else begin
				e_att = 1'b1;
				if (!col_q) begin
					e_mode = MODE_UNDERLAY;
					e_band = BAND_W'(SHARED_BAND);
					e_bo   = '0;
					e_succ = 1'b1;
				end else begin
					v = {1'b0, e_bo, 1'b0} + (fail_q ? '0 : (BO_W+2)'(jit_q));
					if (v > (BO_W+2)'(max_bo_q)) begin
						v = (BO_W+2)'(max_bo_q);
					end
					if (v == '0) begin
						v = (BO_W+2)'(1);
					end
					e_bo = v[BO_W-1:0];
				end
			end
		end
		// a head that just reached the underlay band waits for its next turn to scan
		need_scan = head_ok && (cur_mode == MODE_SEARCHING || cur_mode == MODE_UNDERLAY);
	end

	always_comb begin
		state_nx   = state_q;
		in_stall   = 1'b1;
		scan_start = 1'b0;
		fin_go     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_nx = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (need_scan) begin
					scan_start = 1'b1;
					state_nx   = ST_SCAN;
				end else begin
					state_nx = ST_FINISH;
				end
			end
			ST_SCAN: begin
				if (scan_res.done) begin
					state_nx = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					fin_go   = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	cbac_band_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (scan_start),
		.self      (head_q),
		.pu_active (pu_q),
		.head_mode (mode_q),
		.head_band (band_q),
		.result    (scan_res)
	);

	// item capture and step result
	always_ff @(posedge clk) begin
		if (accept) begin
			head_q <= head;
			pu_q   <= pu_active;
			init_q <= initial_backoff;
			col_q  <= collision;
			fail_q <= backoff_fail;
			jit_q  <= jitter;
		end
		if (state_q == ST_EVAL) begin
			head_ok_q <= head_ok;
			if (head_ok) begin
				was_normal_q <= (cur_mode == MODE_NORMAL);
				nmode_q      <= e_mode;
				nband_q      <= e_band;
				nbo_q        <= e_bo;
				attempt_q    <= e_att;
				success_q    <= e_succ;
			end else begin
				was_normal_q <= 1'b0;
				nmode_q      <= MODE_SEARCHING;
				nband_q      <= '0;
				nbo_q        <= '0;
				attempt_q    <= 1'b0;
				success_q    <= 1'b0;
			end
		end
		if (state_q == ST_SCAN && scan_res.found) begin
			nmode_q <= MODE_NORMAL;
			nband_q <= scan_res.band;
		end
		if (fin_go) begin
			out_head_q   <= head_q;
			out_mode_q   <= nmode_q;
			out_band_q   <= nband_q;
			out_bo_q     <= nbo_q;
			out_deliv_q  <= (nmode_q == MODE_NORMAL);
			out_outage_q <= was_normal_q && (nmode_q != MODE_NORMAL);
			out_att_q    <= attempt_q;
			out_succ_q   <= success_q;
		end
	end

	// per-head state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_HEADS; k++) begin
				mode_q[k] <= MODE_SEARCHING;
				band_q[k] <= '0;
				bo_q[k]   <= '0;
			end
			max_bo_q    <= BO_LIMIT_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				max_bo_q <= backoff_limit;
			end
			if (fin_go && head_ok_q) begin
				mode_q[head_q] <= nmode_q;
				band_q[head_q] <= nband_q;
				bo_q[head_q]   <= nbo_q;
			end
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign head_out         = out_head_q;
	assign mode             = out_mode_q;
	assign band             = out_band_q;
	assign backoff          = out_bo_q;
	assign delivered        = out_deliv_q;
	assign outage_begin     = out_outage_q;
	assign underlay_attempt = out_att_q;
	assign underlay_success = out_succ_q;

endmodule

// ===== tb/tb_cluster_band_access_controller_unit.sv =====
// Self-checking testbench for cluster_band_access_controller_unit: directed and random
// head turns checked against a per-head mode/band/backoff predictor. Depends on cbac_pkg and the unit.
`timescale 1ns / 1ps

module tb_cluster_band_access_controller_unit;
	import cbac_pkg::*;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int SETTLE_LIMIT = 25;
	localparam pu_t ALL_BANDS   = '1;

	typedef struct packed {
		head_t             head;
		pu_t               pu;
		logic [INIT_W-1:0] init;
		logic              col;
		logic              fail;
		logic [JIT_W-1:0]  jit;
	} turn_t;

	typedef struct packed {
		head_t head;
		mode_t mode;
		band_t band;
		bo_t   bo;
		logic  delivered;
		logic  outage;
		logic  attempt;
		logic  success;
	} slot_result_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	head_t             head;
	pu_t               pu_active;
	logic [INIT_W-1:0] initial_backoff;
	logic              collision;
	logic              backoff_fail;
	logic [JIT_W-1:0]  jitter;
	logic              out_valid;
	logic              out_stall;
	head_t             head_out;
	logic [1:0]        mode;
	band_t             band;
	bo_t               backoff;
	logic              delivered;
	logic              outage_begin;
	logic              underlay_attempt;
	logic              underlay_success;
	logic              cfg_valid;
	logic              cfg_ready;
	bo_t               backoff_limit;

	// predictor state
	mode_t ch_mode[NUM_HEADS];
	band_t ch_band[NUM_HEADS];
	bo_t   ch_backoff[NUM_HEADS];
	bo_t   backoff_cap;

	slot_result_t expected_slots[$];
	int err_count;
	int cycle_count;
	int send_idle_pct;
	int stall_pct;

	cluster_band_access_controller_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.head            (head),
		.pu_active       (pu_active),
		.initial_backoff (initial_backoff),
		.collision       (collision),
		.backoff_fail    (backoff_fail),
		.jitter          (jitter),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.head_out        (head_out),
		.mode            (mode),
		.band            (band),
		.backoff         (backoff),
		.delivered       (delivered),
		.outage_begin    (outage_begin),
		.underlay_attempt(underlay_attempt),
		.underlay_success(underlay_success),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.backoff_limit   (backoff_limit)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// one head's turn: updates the predicted state and returns the expected result
	function automatic slot_result_t serve_turn(turn_t t);
		slot_result_t r;
		mode_t m;
		band_t b;
		bo_t bo;
		logic was_normal;
		logic found;
		logic taken;
		int v;
		r = '0;
		r.head = t.head;
		if (t.head >= NUM_HEADS) begin
			return r;
		end
		m = ch_mode[t.head];
		b = ch_band[t.head];
		bo = ch_backoff[t.head];
		was_normal = (m == MODE_NORMAL);
		if (m == MODE_NORMAL && b < NUM_BANDS && t.pu[b]) begin
			m = MODE_DISPLACED;
			bo = bo_t'(t.init);
		end
		if (m == MODE_DISPLACED) begin
			if (bo != 0) begin
				bo = bo - 1'b1;
			end else begin
				r.attempt = 1'b1;
				if (!t.col) begin
					m = MODE_UNDERLAY;
					b = band_t'(SHARED_BAND);
					bo = '0;
					r.success = 1'b1;
				end else begin
					v = 2 * int'(bo) + (t.fail ? 0 : int'(t.jit));
					if (v > int'(backoff_cap)) v = int'(backoff_cap);
					if (v == 0) v = 1;
					bo = bo_t'(v);
				end
			end
		end else if (m == MODE_SEARCHING || m == MODE_UNDERLAY) begin
			found = 1'b0;
			for (int cand = 0; cand < NUM_BANDS && !found; cand++) begin
				taken = t.pu[cand];
				for (int k = 0; k < NUM_HEADS; k++) begin
					if (k != t.head && ch_mode[k] == MODE_NORMAL && ch_band[k] == cand)
						taken = 1'b1;
				end
				if (!taken) begin
					found = 1'b1;
					b = band_t'(cand);
					m = MODE_NORMAL;
				end
			end
		end
		ch_mode[t.head] = m;
		ch_band[t.head] = b;
		ch_backoff[t.head] = bo;
		r.mode = m;
		r.band = b;
		r.bo = bo;
		r.delivered = (m == MODE_NORMAL);
		r.outage = was_normal && (m != MODE_NORMAL);
		return r;
	endfunction

	function automatic turn_t mk_turn(int h, pu_t pu, int init, bit col, bit fail, int jit);
		turn_t t;
		t.head = head_t'(h);
		t.pu = pu;
		t.init = init[INIT_W-1:0];
		t.col = col;
		t.fail = fail;
		t.jit = jit[JIT_W-1:0];
		return t;
	endfunction

	task automatic send_turn(input turn_t t);
		@(negedge clk);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		head <= t.head;
		pu_active <= t.pu;
		initial_backoff <= t.init;
		collision <= t.col;
		backoff_fail <= t.fail;
		jitter <= t.jit;
		do @(posedge clk); while (in_stall);
		expected_slots.push_back(serve_turn(t));
	endtask

	// drop valid, wait for every pending result, then let the sequencer settle
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_slots.size() != 0) @(posedge clk);
		repeat (SETTLE_LIMIT) @(posedge clk);
	endtask

	task automatic write_backoff_limit(input bo_t v);
		wait_drained();
		@(negedge clk);
		cfg_valid <= 1'b1;
		backoff_limit <= v;
		do @(posedge clk); while (!cfg_ready);
		backoff_cap = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic compare_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_count++;
		end
	endtask

	// result checker
	always @(posedge clk) begin
		slot_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_slots.size() == 0) begin
				$error("result for head %0d with no item pending", head_out);
				err_count++;
			end else begin
				e = expected_slots.pop_front();
				compare_field("head_out", e.head, head_out);
				compare_field("mode", e.mode, mode);
				compare_field("band", e.band, band);
				compare_field("backoff", e.bo, backoff);
				compare_field("delivered", e.delivered, delivered);
				compare_field("outage_begin", e.outage, outage_begin);
				compare_field("underlay_attempt", e.attempt, underlay_attempt);
				compare_field("underlay_success", e.success, underlay_success);
			end
		end
	end

	always @(negedge clk) begin
		out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("** cluster_band_access_controller_unit: FAILED **");
		$finish;
	end

	// searching heads grab bands, contention, full occupancy, bad head index
	task automatic test_band_acquisition();
		send_turn(mk_turn(0, '0, 0, 0, 0, 0));
		send_turn(mk_turn(1, '0, 0, 0, 0, 0));
		send_turn(mk_turn(2, ALL_BANDS, 0, 0, 0, 0));
		send_turn(mk_turn(2, 19'h3FFFC, 0, 0, 0, 0));
		send_turn(mk_turn(5, ALL_BANDS, 7, 1, 1, 31));
		send_turn(mk_turn(6, ALL_BANDS, 7, 1, 1, 31));
		send_turn(mk_turn(7, ALL_BANDS, 7, 1, 1, 31));
		send_turn(mk_turn(3, '0, 0, 0, 0, 0));
	endtask

	// displacement, countdown, underlay move and return to a regular band
	task automatic test_displacement_and_underlay();
		send_turn(mk_turn(0, 19'h00001, 0, 0, 0, 0));
		send_turn(mk_turn(1, 19'h00002, 7, 1, 0, 0));
		repeat (6) send_turn(mk_turn(1, '0, 0, 1, 0, 0));
		send_turn(mk_turn(1, '0, 0, 1, 0, 31));
		send_turn(mk_turn(0, '0, 0, 0, 0, 0));
		send_turn(mk_turn(2, 19'h40000, 1, 0, 0, 0));
		send_turn(mk_turn(2, '0, 0, 1, 1, 31));
		send_turn(mk_turn(3, ALL_BANDS, 2, 0, 0, 0));
	endtask

	// repeated collisions on one head under several backoff limits
	task automatic test_collision_backoff();
		bo_t caps[4] = '{10'd0, 10'd1, 10'd1023, 10'd13};
		turn_t t;
		int tries;
		foreach (caps[i]) begin
			write_backoff_limit(caps[i]);
			tries = 0;
			while (tries < 4) begin
				t = mk_turn(4, '0, 0, 1, tries[0], (tries == 0) ? 31 : $urandom_range(31));
				if (ch_mode[4] == MODE_NORMAL) begin
					t.pu = ALL_BANDS;
					tries++;
				end else if (ch_mode[4] == MODE_DISPLACED && ch_backoff[4] == 0) begin
					tries++;
				end
				send_turn(t);
			end
		end
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_chance,
			input bo_t cap, input int count);
		turn_t t;
		int style;
		pu_t sparse;
		write_backoff_limit(cap);
		send_idle_pct = idle_pct;
		stall_pct = stall_chance;
		for (int i = 0; i < count; i++) begin
			if (i == count / 2) wait_drained();
			t.head = ($urandom_range(99) < 6) ? head_t'($urandom_range(7, NUM_HEADS))
				: head_t'($urandom_range(NUM_HEADS - 1));
			sparse = pu_t'($urandom & $urandom & $urandom);
			style = $urandom_range(9);
			case (style)
				0, 1, 2, 3: begin
					t.pu = sparse;
					// aim at the band a normal head holds so it gets displaced
					if (t.head < NUM_HEADS && ch_mode[t.head] == MODE_NORMAL &&
							ch_band[t.head] < NUM_BANDS)
						t.pu[ch_band[t.head]] = 1'b1;
				end
				4, 5: t.pu = '0;
				6: t.pu = ALL_BANDS;
				7: t.pu = pu_t'($urandom);
				default: t.pu = sparse;
			endcase
			t.init = INIT_W'($urandom_range(7));
			t.col = ($urandom_range(99) < 35);
			t.fail = $urandom_range(1);
			t.jit = JIT_W'($urandom_range(31));
			send_turn(t);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		head = '0;
		pu_active = '0;
		initial_backoff = '0;
		collision = 1'b0;
		backoff_fail = 1'b0;
		jitter = '0;
		cfg_valid = 1'b0;
		backoff_limit = '0;
		err_count = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		for (int k = 0; k < NUM_HEADS; k++) begin
			ch_mode[k] = MODE_SEARCHING;
			ch_band[k] = '0;
			ch_backoff[k] = '0;
		end
		backoff_cap = BO_LIMIT_RST;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_band_acquisition();
		test_displacement_and_underlay();
		test_collision_backoff();
		test_random_traffic(0, 0, 10'd512, 225);
		test_random_traffic(77, 0, 10'd1023, 225);
		test_random_traffic(0, 77, bo_t'($urandom_range(31, 1)), 225);
		test_random_traffic(27, 27, 10'd5, 225);
		wait_drained();

		if (err_count == 0) begin
			$display("** cluster_band_access_controller_unit: PASSED **");
		end else begin
			$display("** cluster_band_access_controller_unit: FAILED **");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/cbac_pkg.sv
hdl/cbac_band_scan.sv
hdl/cluster_band_access_controller_unit.sv
tb/tb_cluster_band_access_controller_unit.sv
